[sv/pcm_format_converter_unit_macros.svh]
`ifndef PCM_FORMAT_CONVERTER_UNIT_MACROS_SVH
`define PCM_FORMAT_CONVERTER_UNIT_MACROS_SVH

// Both macros expect the enclosing module to have clk and rst_n.

// The consequent must hold in the same cycle as the antecedent.
`define PCMFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCMFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pcmfc_pkg.sv]
package pcmfc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CHAN_W       = 2;
    localparam int RATE_W       = 18;
    localparam int FRAMES_W     = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int OUT_IDX_W    = 31;
    localparam int NUM_W        = 49;
    localparam int PROD_W       = FRAMES_W + RATE_W;
    localparam int LIMIT_W      = FRAMES_W + RATE_W;
    localparam int DIV_W        = PROD_W + 3;
    localparam int DIV_CNT_W    = $clog2(DIV_W);
    localparam int MAX_UPSAMPLE = 64;
    localparam int UPS_SHIFT    = $clog2(MAX_UPSAMPLE);
    localparam int RES_CAP      = 64;
    localparam int CNT_W        = $clog2(RES_CAP + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CONV_W       = 18;

    // 8-bit samples are offset binary around HALF_SCALE; one byte step is 0x100.
    localparam int HALF_SCALE = 128;
    localparam int BYTE_SHIFT = 8;

    localparam logic [CHAN_W-1:0]   STEREO        = 2'd2;
    localparam logic [FRAMES_W-1:0] IN_INDEX_MAX  = {FRAMES_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_RATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_CHANNELS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_RATE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FRAMES = 3'd6;

    typedef struct packed {
        logic [CHAN_W-1:0]   src_channels;
        logic                src_wide;
        logic [RATE_W-1:0]   src_rate;
        logic [CHAN_W-1:0]   dst_channels;
        logic                dst_wide;
        logic [RATE_W-1:0]   dst_rate;
        logic [FRAMES_W-1:0] source_frames;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        src_channels:  2'd1,
        src_wide:      1'b0,
        src_rate:      18'd44100,
        dst_channels:  2'd1,
        dst_wide:      1'b0,
        dst_rate:      18'd44100,
        source_frames: 24'd0
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
    } sample_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_left;
        logic [SAMPLE_W-1:0] out_right;
        logic                run_last;
        logic                bad_config;
    } result_word_t;

    // One converted frame waiting for the rate stage.
    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                bad;
    } conv_word_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

[sv/pcmfc_total.sv]
module pcmfc_total (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  pcmfc_pkg::cfg_t                cfg,
    output logic [pcmfc_pkg::OUT_IDX_W-1:0] total,
    output logic                           ready
);
    import pcmfc_pkg::*;

    typedef enum logic [1:0] {ST_MUL, ST_ADD, ST_DIV, ST_DONE} state_t;

    state_t                 state_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [RATE_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]   step_reg;
    logic [OUT_IDX_W-1:0]   total_reg;

    logic [1:0]             fb_shift;
    logic [RATE_W:0]        trial;
    logic [RATE_W:0]        diff;
    logic                   q_bit;
    logic [RATE_W-1:0]      rem_step;
    logic [DIV_W-1:0]       quo_step;
    logic [DIV_W-1:0]       dividend;
    logic [DIV_W-1:0]       quo_frames;

    // The destination frame is one, two or four bytes.
    assign fb_shift = {1'b0, cfg.dst_channels == STEREO} + {1'b0, cfg.dst_wide};

    // Rounding up before the division gives the ceiling of the byte count.
    assign dividend = (DIV_W'(prod_reg) << fb_shift) + DIV_W'(cfg.src_rate) - DIV_W'(1);

    // Restoring division, one quotient bit a cycle, most significant first.
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, cfg.src_rate};
    assign q_bit    = !diff[RATE_W];
    assign rem_step = q_bit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    assign quo_step = {quo_reg[DIV_W-2:0], q_bit};
    assign quo_frames = quo_step >> fb_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MUL;
            step_reg  <= '0;
            prod_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
        end
        else if (restart)
        begin
            state_reg <= ST_MUL;
        end
        else
        begin
            unique case (state_reg)
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(cfg.source_frames) * PROD_W'(cfg.dst_rate);
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    quo_reg   <= dividend;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    quo_reg  <= quo_step;
                    rem_reg  <= rem_step;
                    step_reg <= step_reg + DIV_CNT_W'(1);
                    if (step_reg == DIV_CNT_W'(DIV_W - 1))
                    begin
                        total_reg <= quo_frames[OUT_IDX_W-1:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_DONE;
                end
            endcase
        end
    end

    assign total = total_reg;
    assign ready = (state_reg == ST_DONE);

endmodule

[sv/pcmfc_front.sv]
module pcmfc_front (
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  pcmfc_pkg::sample_word_t sample,
    input  pcmfc_pkg::cfg_t         cfg,
    input  logic                    total_ready,
    input  pcmfc_pkg::q_status_t    q_status,
    output logic                    push,
    output pcmfc_pkg::conv_word_t   push_word
);
    import pcmfc_pkg::*;

    logic                     s_st;
    logic                     d_st;
    logic                     bad;
    logic signed [CONV_W-1:0] l0;
    logic signed [CONV_W-1:0] r0;
    logic signed [CONV_W-1:0] sum;
    logic signed [CONV_W-1:0] avg;
    logic signed [CONV_W-1:0] l1;
    logic signed [CONV_W-1:0] r1;
    logic signed [CONV_W-1:0] l2;
    logic signed [CONV_W-1:0] r2;

    // 16 to 8 bits: divide by 0x100 towards zero, then add the offset.
    function automatic logic signed [CONV_W-1:0] narrow(input logic signed [CONV_W-1:0] x);
        logic signed [CONV_W-1:0] t;
        t = x + (x[CONV_W-1] ? CONV_W'((1 << BYTE_SHIFT) - 1) : CONV_W'(0));
        return (t >>> BYTE_SHIFT) + CONV_W'(HALF_SCALE);
    endfunction

    // 8 to 16 bits: remove the offset and scale by 0x100.
    function automatic logic signed [CONV_W-1:0] widen(input logic signed [CONV_W-1:0] x);
        return (x - CONV_W'(HALF_SCALE)) <<< BYTE_SHIFT;
    endfunction

    function automatic logic signed [CONV_W-1:0] decode(input logic [SAMPLE_W-1:0] raw,
                                                        input logic wide);
        return wide ? {{(CONV_W-SAMPLE_W){raw[SAMPLE_W-1]}}, raw}
                    : {{(CONV_W-8){1'b0}}, raw[7:0]};
    endfunction

    assign s_st = (cfg.src_channels == STEREO);
    assign d_st = (cfg.dst_channels == STEREO);

    assign bad = (cfg.src_rate == '0) ||
                 ({{UPS_SHIFT{1'b0}}, cfg.dst_rate} > {cfg.src_rate, {UPS_SHIFT{1'b0}}});

    always_comb
    begin
        l0 = decode(sample.left_sample, cfg.src_wide);
        r0 = s_st ? decode(sample.right_sample, cfg.src_wide) : l0;

        // Halve the sum towards zero; for unsigned 8-bit words this is the floor.
        sum = l0 + r0;
        avg = (sum + (sum[CONV_W-1] ? CONV_W'(1) : CONV_W'(0))) >>> 1;

        l1 = (s_st && !d_st) ? avg : l0;
        r1 = d_st ? r0 : '0;

        if (cfg.src_wide && !cfg.dst_wide)
        begin
            l2 = narrow(l1);
            r2 = narrow(r1);
        end
        else if (!cfg.src_wide && cfg.dst_wide)
        begin
            l2 = widen(l1);
            r2 = widen(r1);
        end
        else
        begin
            l2 = l1;
            r2 = r1;
        end

        push_word.left  = cfg.dst_wide ? l2[SAMPLE_W-1:0] : {8'h00, l2[7:0]};
        push_word.right = !d_st        ? '0
                        : cfg.dst_wide ? r2[SAMPLE_W-1:0] : {8'h00, r2[7:0]};
        push_word.bad   = bad;
        if (bad)
        begin
            push_word.left  = '0;
            push_word.right = '0;
        end
    end

    assign sample_stall = !total_ready || q_status.full;
    assign push         = sample_valid && !sample_stall;

endmodule

[sv/pcmfc_fifo.sv]
`include "pcm_format_converter_unit_macros.svh"

module pcmfc_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pcmfc_pkg::conv_word_t push_word,
    input  logic                  pop,
    output pcmfc_pkg::conv_word_t head,
    output pcmfc_pkg::q_status_t  q_status
);
    import pcmfc_pkg::*;

    conv_word_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head           = slot_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    `PCMFC_ASSERT_IMP(a_no_push_full, push, !q_status.full, "word pushed into a full queue")
    `PCMFC_ASSERT_IMP(a_no_pop_empty, pop, !q_status.empty, "word popped from an empty queue")
    `PCMFC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

[sv/pcmfc_back.sv]
`include "pcm_format_converter_unit_macros.svh"

module pcmfc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            restart,
    input  pcmfc_pkg::cfg_t                 cfg,
    input  logic [pcmfc_pkg::OUT_IDX_W-1:0] total,
    input  pcmfc_pkg::q_status_t            q_status,
    input  pcmfc_pkg::conv_word_t           head,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output pcmfc_pkg::result_word_t         result
);
    import pcmfc_pkg::*;

    typedef enum logic {ST_WAIT, ST_RUN} state_t;

    state_t                state_reg,     state_next;
    conv_word_t            cur_reg,       cur_next;
    logic [OUT_IDX_W-1:0]  idx_reg,       idx_next;
    logic [NUM_W-1:0]      num_reg,       num_next;
    logic [LIMIT_W-1:0]    base_reg,      base_next;
    logic [LIMIT_W-1:0]    limit_reg,     limit_next;
    logic [FRAMES_W-1:0]   in_idx_reg,    in_idx_next;
    logic [CNT_W-1:0]      cnt_reg,       cnt_next;
    logic                  out_valid_reg, out_valid_next;
    result_word_t          out_word_reg,  out_word_next;

    logic                  space;
    logic                  more;
    logic                  last;
    logic                  emit;
    logic                  finish;
    logic [OUT_IDX_W-1:0]  idx_inc;
    logic [NUM_W-1:0]      num_inc;
    logic [CNT_W-1:0]      cnt_inc;

    assign space   = !out_valid_reg || !result_stall;
    assign idx_inc = idx_reg + OUT_IDX_W'(1);
    assign num_inc = num_reg + NUM_W'(cfg.src_rate);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    // Output frame a belongs to this source frame while a*src_rate is below
    // (frame index + 1)*dst_rate; the lookahead tells whether this one is the last.
    assign more = (idx_reg < total) && (num_reg < NUM_W'(limit_reg)) &&
                  (cnt_reg < CNT_W'(RES_CAP));
    assign last = !((idx_inc < total) && (num_inc < NUM_W'(limit_reg)) &&
                    (cnt_inc < CNT_W'(RES_CAP)));

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        base_next      = base_reg;
        limit_next     = limit_reg;
        in_idx_next    = in_idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_word_next  = out_word_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        finish         = 1'b0;

        unique case (state_reg)
            ST_WAIT:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    limit_next = base_reg + LIMIT_W'(cfg.dst_rate);
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cur_reg.bad)
                begin
                    // A bad ratio gives one error word and leaves the counters alone.
                    if (space)
                    begin
                        out_valid_next           = 1'b1;
                        out_word_next.out_left   = '0;
                        out_word_next.out_right  = '0;
                        out_word_next.run_last   = 1'b1;
                        out_word_next.bad_config = 1'b1;
                        state_next               = ST_WAIT;
                    end
                end
                else if (!more)
                begin
                    finish     = 1'b1;
                    state_next = ST_WAIT;
                end
                else if (space)
                begin
                    emit                     = 1'b1;
                    out_valid_next           = 1'b1;
                    out_word_next.out_left   = cur_reg.left;
                    out_word_next.out_right  = cur_reg.right;
                    out_word_next.run_last   = last;
                    out_word_next.bad_config = 1'b0;
                    idx_next                 = idx_inc;
                    num_next                 = num_inc;
                    cnt_next                 = cnt_inc;
                    if (last)
                    begin
                        finish     = 1'b1;
                        state_next = ST_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase

        if (finish && (in_idx_reg != IN_INDEX_MAX))
        begin
            in_idx_next = in_idx_reg + FRAMES_W'(1);
            base_next   = base_reg + LIMIT_W'(cfg.dst_rate);
        end

        if (restart)
        begin
            state_next  = ST_WAIT;
            idx_next    = '0;
            num_next    = '0;
            base_next   = '0;
            in_idx_next = '0;
            cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            cur_reg       <= '0;
            idx_reg       <= '0;
            num_reg       <= '0;
            base_reg      <= '0;
            limit_reg     <= '0;
            in_idx_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            idx_reg       <= idx_next;
            num_reg       <= num_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            in_idx_reg    <= in_idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    `PCMFC_ASSERT_IMP(a_pop_in_wait, pop, (state_reg == ST_WAIT) && !q_status.empty,
        "queue popped outside the wait state")
    `PCMFC_ASSERT_NXT(a_emit_steps, emit && !restart, idx_reg == $past(idx_reg) + OUT_IDX_W'(1),
        "output index did not advance by one")
    `PCMFC_ASSERT_IMP(a_idx_bound, out_valid_reg && !out_word_reg.bad_config, idx_reg <= total,
        "output index ran past the total")
    `PCMFC_ASSERT_IMP(a_err_word, out_valid_reg && out_word_reg.bad_config,
        out_word_reg.run_last && (out_word_reg.out_left == '0) && (out_word_reg.out_right == '0),
        "malformed error word")

endmodule

[sv/pcm_format_converter_unit.sv]
// Channel  Direction  Handshake                     Word
// sample   in         sample_valid / sample_stall   left_sample, right_sample
// result   out        result_valid / result_stall   out_left, out_right, run_last, bad_config
// cfg      in         cfg_write                     cfg_index, cfg_data
//
// A taken frame waits in the two-entry queue until the rate stage pops it in its wait
// state, then registers one output word a cycle unless a stalled result word holds it;
// a frame with no output word still passes through the rate stage before the next is taken.
// After reset and after every register write, sample_stall stays high
// while the output total is worked out (one multiply, one add, a 45-step divider).
// A stalled result word holds in the output register; the queue fills up behind it.
module pcm_format_converter_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  pcmfc_pkg::sample_word_t          sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output pcmfc_pkg::result_word_t          result,
    input  logic                             cfg_write,
    input  logic [pcmfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcmfc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcmfc_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic                  restart;
    logic [OUT_IDX_W-1:0]  total;
    logic                  total_ready;
    q_status_t             q_status;
    logic                  push;
    conv_word_t            push_word;
    logic                  pop;
    conv_word_t            head;

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_write)
        begin
            restart = 1'b1;
            unique case (cfg_index)
                CFG_SRC_CHANNELS:  cfg_next.src_channels  = cfg_data[CHAN_W-1:0];
                CFG_SRC_WIDE:      cfg_next.src_wide      = cfg_data[0];
                CFG_SRC_RATE:      cfg_next.src_rate      = cfg_data[RATE_W-1:0];
                CFG_DST_CHANNELS:  cfg_next.dst_channels  = cfg_data[CHAN_W-1:0];
                CFG_DST_WIDE:      cfg_next.dst_wide      = cfg_data[0];
                CFG_DST_RATE:      cfg_next.dst_rate      = cfg_data[RATE_W-1:0];
                CFG_SOURCE_FRAMES: cfg_next.source_frames = cfg_data[FRAMES_W-1:0];
                default:           restart                = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcmfc_total u_total (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .cfg     (cfg_reg),
        .total   (total),
        .ready   (total_ready)
    );

    pcmfc_front u_front (
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cfg          (cfg_reg),
        .total_ready  (total_ready),
        .q_status     (q_status),
        .push         (push),
        .push_word    (push_word)
    );

    pcmfc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    pcmfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .cfg          (cfg_reg),
        .total        (total),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
